// ----- hdl/m16bgr_pkg.sv -----
// ----------------------------------------------------------------------------
// m16bgr_pkg
// Shared constants and types for the 16-bit gray to BGR8 max-normalizing
// converter: frame geometry, index widths, config register codes.
// ----------------------------------------------------------------------------
package m16bgr_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int ADDR_W     = $clog2(MAX_PIXELS);
	localparam int IDX_W      = $clog2(MAX_PIXELS + 1);

	localparam int PIX_W  = 16;
	localparam int BYTE_W = 8;
	localparam int DIM_W  = 9;
	localparam int DIV_W  = 9;
	localparam int CFG_W  = 9;
	localparam int CIDX_W = 1;

	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(256);

	// x / 255 == (x * 0x8081) >> 23 for every 16-bit x
	localparam logic [PIX_W-1:0] RECIP_255   = 16'h8081;
	localparam int               RECIP_SHIFT = 23;

	typedef enum logic [CIDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_EMIT = 1'b1
	} mode_t;

endpackage

// ----- hdl/m16bgr_ram.sv -----
// ----------------------------------------------------------------------------
// m16bgr_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module m16bgr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/mono16_to_bgr8_max_normalize.sv -----
// ----------------------------------------------------------------------------
// mono16_to_bgr8_max_normalize
// Stores a frame of 16-bit gray pixels in a frame RAM while tracking the
// maximum, then reads it back in order divided by max/255+1 onto B, G and R.
// ----------------------------------------------------------------------------
// load item: taken in IDLE, next item may follow in the next cycle unless the output is stalled
// emit item of a complete frame: registered RAM read, then states READ, DIV and DONE
//   (divider load from the RAM word, 8 divider steps, one output load);
//   the next item is taken only after DONE returns to IDLE, which waits for a free output
// emit item before the frame is complete: zero result valid in the cycle after accept
// reset clears indices, maximum and completion flag; frame RAM is not cleared
// ----------------------------------------------------------------------------
module mono16_to_bgr8_max_normalize
	import m16bgr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [PIX_W-1:0]  pixel,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] blue,
	output logic [BYTE_W-1:0] green,
	output logic [BYTE_W-1:0] red,
	output logic              last_pixel,
	output logic              ready_res
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0]  width_q, height_q;
	logic [PIX_W-1:0]  max_q;
	logic [IDX_W-1:0]  widx_q, ridx_q;
	logic [DIV_W-1:0]  div_q;
	logic              complete_q;
	logic              oob_q;

	logic [DIV_W-1:0]  rem_q;
	logic [BYTE_W-1:0] quo_q;
	logic [2:0]        step_q;
	logic              sat_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_ready_q;

	// frame size
	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [2*DIM_W-1:0] n_prod;
	logic [IDX_W-1:0]   n_pix;

	always_comb begin
		w_eff  = (width_q == '0) ? DIM_W'(1) : ((width_q > DIM_MAX) ? DIM_MAX : width_q);
		h_eff  = (height_q == '0) ? DIM_W'(1) : ((height_q > DIM_MAX) ? DIM_MAX : height_q);
		n_prod = w_eff * h_eff;
		n_pix  = (n_prod > (2*DIM_W)'(MAX_PIXELS)) ? IDX_W'(MAX_PIXELS) : IDX_W'(n_prod);
	end

	logic in_acc, out_take, out_free;
	logic do_load, do_emit_zero, do_emit;

	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	assign do_load      = in_acc && (mode == MODE_LOAD) && !complete_q;
	assign do_emit_zero = in_acc && (mode == MODE_EMIT) && !complete_q;
	assign do_emit      = in_acc && (mode == MODE_EMIT) && complete_q;

	// load path
	logic             wr_ok;
	logic [IDX_W-1:0] widx_nxt;

	assign wr_ok    = widx_q < IDX_W'(MAX_PIXELS);
	assign widx_nxt = wr_ok ? (widx_q + IDX_W'(1)) : widx_q;

	// frame RAM
	logic [PIX_W-1:0] rd_data;

	m16bgr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_PIXELS)
	) u_frame_ram (
		.clk     (clk),
		.we      (do_load && wr_ok),
		.wr_addr (widx_q[ADDR_W-1:0]),
		.wr_data (pixel),
		.re      (do_emit),
		.rd_addr (ridx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// divider operands
	logic [DIV_W-1:0]   d_eff;
	logic [PIX_W-1:0]   v_rd;
	logic [DIV_W:0]     trial;
	logic               q_bit;
	logic [2*PIX_W-1:0] max_prod;
	logic [IDX_W-1:0]   ridx_nxt;
	logic               is_last;

	always_comb begin
		d_eff    = (div_q == '0) ? DIV_W'(1) : div_q;
		v_rd     = oob_q ? '0 : rd_data;
		trial    = {rem_q, quo_q[BYTE_W-1]};
		q_bit    = trial >= {1'b0, d_eff};
		max_prod = max_q * RECIP_255;
		ridx_nxt = ridx_q + IDX_W'(1);
		is_last  = ridx_nxt >= n_pix;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_MAX;
			height_q <= DIM_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// divisor follows the running maximum; it is stable during readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= DIV_W'(1);
		end else begin
			div_q <= DIV_W'(max_prod[2*PIX_W-1:RECIP_SHIFT]) + DIV_W'(1);
		end
	end

	// frame control and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_q      <= '0;
			widx_q     <= '0;
			ridx_q     <= '0;
			complete_q <= 1'b0;
			oob_q      <= 1'b0;
			step_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (do_load) begin
						widx_q <= widx_nxt;
						if (wr_ok && pixel > max_q) begin
							max_q <= pixel;
						end
						if (widx_nxt >= n_pix) begin
							complete_q <= 1'b1;
						end
					end
					if (do_emit) begin
						oob_q   <= !(ridx_q < IDX_W'(MAX_PIXELS));
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (is_last) begin
							max_q      <= '0;
							widx_q     <= '0;
							ridx_q     <= '0;
							complete_q <= 1'b0;
						end else begin
							ridx_q <= ridx_nxt;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// bit-serial divider: high byte seeds the remainder, low byte shifts through
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			sat_q <= {1'b0, v_rd} >= {d_eff, {BYTE_W{1'b0}}};
			rem_q <= DIV_W'(v_rd[PIX_W-1:BYTE_W]);
			quo_q <= v_rd[BYTE_W-1:0];
		end else if (state_q == ST_DIV) begin
			rem_q <= q_bit ? DIV_W'(trial - {1'b0, d_eff}) : trial[DIV_W-1:0];
			quo_q <= {quo_q[BYTE_W-2:0], q_bit};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit_zero || (state_q == ST_DONE && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit_zero) begin
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_ready_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_byte_q  <= sat_q ? {BYTE_W{1'b1}} : quo_q;
			out_last_q  <= is_last;
			out_ready_q <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign blue       = out_byte_q;
	assign green      = out_byte_q;
	assign red        = out_byte_q;
	assign last_pixel = out_last_q;
	assign ready_res  = out_ready_q;

endmodule

// ----- hdl/m16bgr_chk.sv -----
// ----------------------------------------------------------------------------
// m16bgr_chk
// Port-level checks for the gray to BGR8 converter, bound to the top level.
// ----------------------------------------------------------------------------
module m16bgr_chk
	import m16bgr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [BYTE_W-1:0] blue,
	input logic [BYTE_W-1:0] green,
	input logic [BYTE_W-1:0] red,
	input logic              last_pixel,
	input logic              ready_res
);

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(blue) && $stable(last_pixel)
			&& $stable(ready_res))
		else $error("stalled output item changed");

	// an item from an incomplete frame is all zero
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ready_res |-> blue == '0 && green == '0 && red == '0 && !last_pixel)
		else $error("not-ready item carries data");

	// all three channels carry the same gray byte
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> blue == green && green == red)
		else $error("color channels differ");

	// frame end is only marked on a real pixel
	a_last_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> ready_res)
		else $error("last pixel without ready");

endmodule

bind mono16_to_bgr8_max_normalize m16bgr_chk u_m16bgr_chk (.*);
